/* src/trc_pkg.sv */
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types, constants and helper functions for the texture resample and
// convert block: store geometry, format codes, target size and step logic,
// and the texel packing function.
// ----------------------------------------------------------------------------
package trc_pkg;

  // Source store geometry
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PTR_W       = $clog2(STORE_DEPTH + 1);

  // Largest power-of-two target dimension, and its log2 (rounded down)
  localparam int MAX_POW_DIM = 512;
  localparam int MAX_LOG2    = $clog2(MAX_POW_DIM + 1) - 1;
  localparam int MIN_LOG2    = 3;

  // Field widths
  localparam int DIM_W   = 10;
  localparam int FRAC_W  = 16;
  localparam int STEP_W  = 26;
  localparam int IDX_W   = 20;
  localparam int WORD_W  = 32;
  localparam int TEXEL_W = 16;
  localparam int FMT_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_W;
  localparam logic [DIM_W-1:0]  TGT_RESET = DIM_W'(8);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_MODE   = 2'd2;

  // Texel formats
  localparam logic [FMT_W-1:0] FMT_RGB565   = 2'd0;
  localparam logic [FMT_W-1:0] FMT_ARGB1555 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_ARGB4444 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_COPY     = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic take;   // input transfer this cycle
    logic load;   // write latched pixel into the store
    logic index;  // form source index, advance the raster counters
    logic emit;   // pack texel into the output register
  } trc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done;      // last texel of the image already indexed
    logic out_free;  // output register can take a texel this cycle
  } trc_stat_t;

  // Smallest power of two from 8 up that covers dim, else dim itself
  function automatic logic [DIM_W-1:0] pow_target(input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] res;
    logic             found;
    res   = dim;
    found = 1'b0;
    for (int k = MIN_LOG2; k <= MAX_LOG2; k++) begin
      if (!found && (dim <= DIM_W'(1 << k))) begin
        res   = DIM_W'(1 << k);
        found = 1'b1;
      end
    end
    return res;
  endfunction

  // (dim << 16) / target, exact: a shift for power-of-two targets
  function automatic logic [STEP_W-1:0] make_step(input logic [DIM_W-1:0] dim);
    logic [STEP_W-1:0] res;
    logic              found;
    res   = STEP_ONE;
    found = 1'b0;
    for (int k = MIN_LOG2; k <= MAX_LOG2; k++) begin
      if (!found && (dim <= DIM_W'(1 << k))) begin
        res   = {dim, {FRAC_W{1'b0}}} >> k;
        found = 1'b1;
      end
    end
    return res;
  endfunction

  // Pack r,g,b,a bytes into the selected 16-bit format
  function automatic logic [TEXEL_W-1:0] pack_texel(input logic [WORD_W-1:0] w,
                                                    input logic [FMT_W-1:0]  mode);
    logic [7:0]         r, g, b, a;
    logic [TEXEL_W-1:0] res;
    r = w[7:0];
    g = w[15:8];
    b = w[23:16];
    a = w[31:24];
    case (mode)
      FMT_RGB565:   res = {r[7:3], g[7:2], b[7:3]};
      FMT_ARGB1555: res = {a[0], r[7:3], g[7:3], b[7:3]};
      FMT_ARGB4444: res = {a[7:4], r[7:4], g[7:4], b[7:4]};
      FMT_COPY:     res = w[15:0];
      default:      res = w[15:0];
    endcase
    return res;
  endfunction

endpackage

/* src/texture_resample_convert.sv */
// ----------------------------------------------------------------------------
// texture_resample_convert
// Nearest-neighbour texture scaler to a power-of-two target (kept at the source
// size above 512) with 16-bit texel conversion (RGB565, ARGB1555, ARGB4444 or plain copy).
// ----------------------------------------------------------------------------
// One item is handled at a time. A load item goes through the transfer
// and load steps before the next item can be taken; an emit item goes
// through transfer, index multiply, store read and pack, since the index
// is registered after the row by source width multiply and the source
// store's read port is registered. An emit that arrives after the last
// texel of the image gives no texel and ends at its index step. A finished
// texel sits in an output register, so the next item is taken while it
// waits; an emit only stalls in the pack step if the previous texel has
// still not been taken. A start request takes effect in the transfer
// cycle, before the item itself. The store needs no clearing after reset;
// its entries are undefined until loaded.
// ----------------------------------------------------------------------------
module texture_resample_convert (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic                           start_req_i,
  input  logic [trc_pkg::WORD_W-1:0]     pixel_word_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [trc_pkg::TEXEL_W-1:0]    texel_o,
  output logic [trc_pkg::IDX_W-1:0]      texel_index_o,
  output logic                           last_o,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [trc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  trc_pkg::trc_cmd_t  cmd;
  trc_pkg::trc_stat_t stat;

  trc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  trc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .start_req_i   (start_req_i),
    .pixel_word_i  (pixel_word_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .texel_o       (texel_o),
    .texel_index_o (texel_index_o),
    .last_o        (last_o)
  );

endmodule

/* src/trc_ram.sv */
// ----------------------------------------------------------------------------
// trc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module trc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/trc_ctrl.sv */
// ----------------------------------------------------------------------------
// trc_ctrl
// Controller for the texture resample and convert block. Takes one item at a
// time and steps the datapath through load or index, read and pack.
// ----------------------------------------------------------------------------
module trc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  trc_pkg::trc_stat_t stat_i,
  output trc_pkg::trc_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_INDEX = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_PACK  = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = kind_i ? S_INDEX : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_IDLE;
      end
      S_INDEX: begin
        // no texel once the image has finished
        if (stat_i.done) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.index = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        state_d = S_PACK;
      end
      S_PACK: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/trc_datapath.sv */
// ----------------------------------------------------------------------------
// trc_datapath
// Datapath: configuration registers, source store, load pointer, raster
// counters and fixed-point accumulators, index multiply, texel packing and
// the output register.
// ----------------------------------------------------------------------------
module trc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  trc_pkg::trc_cmd_t                 cmd_i,
  output trc_pkg::trc_stat_t                stat_o,
  input  logic                              start_req_i,
  input  logic [trc_pkg::WORD_W-1:0]        pixel_word_i,
  input  logic                              cfg_we_i,
  input  logic [trc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [trc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [trc_pkg::TEXEL_W-1:0]       texel_o,
  output logic [trc_pkg::IDX_W-1:0]         texel_index_o,
  output logic                              last_o
);

  // Configuration
  logic [trc_pkg::DIM_W-1:0]  src_w_q, src_h_q;
  logic [trc_pkg::FMT_W-1:0]  fmt_q;

  // Image state
  logic [trc_pkg::PTR_W-1:0]  ptr_q, ptr_d;
  logic [trc_pkg::DIM_W-1:0]  tgt_w_q, tgt_w_d, tgt_h_q, tgt_h_d;
  logic [trc_pkg::STEP_W-1:0] step_x_q, step_x_d, step_y_q, step_y_d;
  logic [trc_pkg::STEP_W-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [trc_pkg::DIM_W-1:0]  col_q, col_d, row_q, row_d;
  logic [trc_pkg::IDX_W-1:0]  oidx_q, oidx_d;
  logic                       done_q, done_d;

  // Item and texel stage
  logic [trc_pkg::WORD_W-1:0] word_q;
  logic [trc_pkg::IDX_W-1:0]  idx_q;
  logic                       oob_q;
  logic                       last_q;
  logic [trc_pkg::IDX_W-1:0]  tidx_q;

  // Output register
  logic                        ovalid_q;
  logic [trc_pkg::TEXEL_W-1:0] otexel_q;
  logic [trc_pkg::IDX_W-1:0]   oindex_q;
  logic                        olast_q;

  logic [trc_pkg::IDX_W-1:0]  prod;
  logic [trc_pkg::IDX_W-1:0]  idx_calc;
  logic                       last_calc;
  logic [trc_pkg::DIM_W-1:0]  col_inc;
  logic                       row_wrap;
  logic                       store_we;
  logic [trc_pkg::WORD_W-1:0] rdata;
  logic [trc_pkg::WORD_W-1:0] src_word;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= trc_pkg::DIM_W'(1);
      src_h_q <= trc_pkg::DIM_W'(1);
      fmt_q   <= trc_pkg::FMT_RGB565;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        trc_pkg::CFG_SOURCE_WIDTH:  src_w_q <= cfg_data_i;
        trc_pkg::CFG_SOURCE_HEIGHT: src_h_q <= cfg_data_i;
        trc_pkg::CFG_FORMAT_MODE:   fmt_q   <= cfg_data_i[trc_pkg::FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // Source index and end-of-image test from the current position
  assign prod      = trc_pkg::IDX_W'(acc_y_q[trc_pkg::STEP_W-1:trc_pkg::FRAC_W])
                   * trc_pkg::IDX_W'(src_w_q);
  assign idx_calc  = prod + trc_pkg::IDX_W'(acc_x_q[trc_pkg::STEP_W-1:trc_pkg::FRAC_W]);
  assign last_calc = (({1'b0, col_q} + 11'd1) >= {1'b0, tgt_w_q}) &&
                     (({1'b0, row_q} + 11'd1) >= {1'b0, tgt_h_q});
  assign col_inc   = col_q + trc_pkg::DIM_W'(1);
  assign row_wrap  = (col_inc >= tgt_w_q);

  // Image state update: start at transfer, pointer on load, raster on index
  always_comb begin
    ptr_d    = ptr_q;
    tgt_w_d  = tgt_w_q;
    tgt_h_d  = tgt_h_q;
    step_x_d = step_x_q;
    step_y_d = step_y_q;
    acc_x_d  = acc_x_q;
    acc_y_d  = acc_y_q;
    col_d    = col_q;
    row_d    = row_q;
    oidx_d   = oidx_q;
    done_d   = done_q;
    if (cmd_i.take && start_req_i) begin
      ptr_d    = '0;
      tgt_w_d  = trc_pkg::pow_target(src_w_q);
      tgt_h_d  = trc_pkg::pow_target(src_h_q);
      step_x_d = trc_pkg::make_step(src_w_q);
      step_y_d = trc_pkg::make_step(src_h_q);
      acc_x_d  = '0;
      acc_y_d  = '0;
      col_d    = '0;
      row_d    = '0;
      oidx_d   = '0;
      done_d   = 1'b0;
    end
    if (store_we) begin
      ptr_d = ptr_q + trc_pkg::PTR_W'(1);
    end
    if (cmd_i.index) begin
      if (last_calc) begin
        done_d = 1'b1;
      end else begin
        oidx_d = oidx_q + trc_pkg::IDX_W'(1);
        if (row_wrap) begin
          col_d   = '0;
          acc_x_d = '0;
          row_d   = row_q + trc_pkg::DIM_W'(1);
          acc_y_d = acc_y_q + step_y_q;
        end else begin
          col_d   = col_inc;
          acc_x_d = acc_x_q + step_x_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      tgt_w_q  <= trc_pkg::TGT_RESET;
      tgt_h_q  <= trc_pkg::TGT_RESET;
      step_x_q <= '0;
      step_y_q <= '0;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
      col_q    <= '0;
      row_q    <= '0;
      oidx_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      tgt_w_q  <= tgt_w_d;
      tgt_h_q  <= tgt_h_d;
      step_x_q <= step_x_d;
      step_y_q <= step_y_d;
      acc_x_q  <= acc_x_d;
      acc_y_q  <= acc_y_d;
      col_q    <= col_d;
      row_q    <= row_d;
      oidx_q   <= oidx_d;
      done_q   <= done_d;
    end
  end

  // Item payload and texel stage registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      word_q <= pixel_word_i;
    end
    if (cmd_i.index) begin
      idx_q  <= idx_calc;
      oob_q  <= ({1'b0, idx_calc} >= (trc_pkg::IDX_W + 1)'(trc_pkg::STORE_DEPTH));
      last_q <= last_calc;
      tidx_q <= oidx_q;
    end
  end

  // Source store; loads past capacity are dropped
  assign store_we = cmd_i.load && (ptr_q < trc_pkg::PTR_W'(trc_pkg::STORE_DEPTH));

  trc_ram #(
    .WIDTH (trc_pkg::WORD_W),
    .DEPTH (trc_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (ptr_q[trc_pkg::ADDR_W-1:0]),
    .wdata_i (word_q),
    .raddr_i (idx_q[trc_pkg::ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  assign src_word = oob_q ? '0 : rdata;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      otexel_q <= trc_pkg::pack_texel(src_word, fmt_q);
      oindex_q <= tidx_q;
      olast_q  <= last_q;
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.out_free = !ovalid_q || out_ready_i;

  assign out_valid_o   = ovalid_q;
  assign texel_o       = otexel_q;
  assign texel_index_o = oindex_q;
  assign last_o        = olast_q;

endmodule
